FILE: hdl/mwcu_pkg.sv
// ----------------------------------------------------------------------------
// mwcu_pkg
// Shared constants and helpers for the multiply-with-carry identifier
// string generator.
// ----------------------------------------------------------------------------
package mwcu_pkg;

   localparam int WORD_W      = 32;
   localparam int HALF_W      = 16;
   localparam int NUM_WORDS   = 4;
   localparam int NUM_CHARS   = 36;
   localparam int NUM_NIBBLES = 32;
   localparam int DATA_W      = WORD_W * NUM_WORDS;
   localparam int CHAR_W      = 7;
   localparam int INDEX_W     = 6;
   localparam int ADDR_W      = 4;

   localparam logic [HALF_W-1:0] MULT_Z = 16'd36969;
   localparam logic [HALF_W-1:0] MULT_W = 16'd18000;

   localparam logic [WORD_W-1:0] SEED_W_RESET = 32'd1;
   localparam logic [WORD_W-1:0] SEED_Z_RESET = 32'd2;

   localparam logic [WORD_W-1:0] V4_W1_MASK = 32'hFFF0FFFF;
   localparam logic [WORD_W-1:0] V4_W1_SET  = 32'h00040000;
   localparam logic [WORD_W-1:0] V4_W2_MASK = 32'hFFFFFFF3;
   localparam logic [WORD_W-1:0] V4_W2_SET  = 32'h00000008;

   localparam logic [CHAR_W-1:0] CHAR_DASH = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_A    = 7'h61;

   // register indexes
   localparam logic [1:0] REG_SEED_W  = 2'd0;
   localparam logic [1:0] REG_SEED_Z  = 2'd1;
   localparam logic [1:0] REG_VARIANT = 2'd2;

   // which generator word the shared unit updates
   typedef enum logic {
      SEL_Z = 1'b0,
      SEL_W = 1'b1
   } gen_sel_type;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] code;
      if (nib < 4'd10) begin
         code = CHAR_ZERO + {3'b000, nib};
      end else begin
         code = CHAR_A + {3'b000, nib - 4'd10};
      end
      return code;
   endfunction

endpackage

FILE: hdl/mwc_uuid_string_generator.sv
// ----------------------------------------------------------------------------
// mwc_uuid_string_generator
// Random identifier string generator built on two multiply-with-carry words.
// ----------------------------------------------------------------------------
// Each accepted request (optionally reseeding from the seed registers) runs
// four generator draws through one shared multiply-add unit, one generator
// word per cycle. The 36 characters then leave one per cycle while
// rsp_ready is high. req_ready is high only while the block is idle.
// Variant-4 mode forces the version and variant bit patterns into words
// 1 and 2.
module mwc_uuid_string_generator (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_reseed,
   // character channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mwcu_pkg::CHAR_W-1:0]   rsp_char_code,
   output logic [mwcu_pkg::INDEX_W-1:0]  rsp_char_index,
   output logic                          rsp_last_char,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mwcu_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [mwcu_pkg::WORD_W-1:0]   csr_pwdata,
   output logic [mwcu_pkg::WORD_W-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import mwcu_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAW,
      ST_EMIT
   } state_type;

   state_type          state_ff;
   logic [WORD_W-1:0]  seed_w_ff;
   logic [WORD_W-1:0]  seed_z_ff;
   logic               variant_ff;
   logic [WORD_W-1:0]  gen_w_ff;
   logic [WORD_W-1:0]  gen_z_ff;
   logic [DATA_W-1:0]  data_ff;
   logic [2:0]         step_ff;
   logic [4:0]         nib_ff;
   logic               dash_done_ff;
   logic [INDEX_W-1:0] char_cnt_ff;
   logic               rsp_valid_ff;
   logic [CHAR_W-1:0]  char_code_ff;
   logic [INDEX_W-1:0] char_index_ff;
   logic               last_char_ff;

   logic               csr_write;
   logic [1:0]         csr_index;
   gen_sel_type        unit_sel;
   logic [WORD_W-1:0]  unit_in;
   logic [WORD_W-1:0]  unit_out;
   logic [WORD_W-1:0]  word_in;
   logic [1:0]         word_idx;
   logic               emit_advance;
   logic               dash_now;
   logic [CHAR_W-1:0]  char_in;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_index)
         REG_SEED_W:  csr_prdata = seed_w_ff;
         REG_SEED_Z:  csr_prdata = seed_z_ff;
         REG_VARIANT: csr_prdata = {{(WORD_W-1){1'b0}}, variant_ff};
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_w_ff  <= SEED_W_RESET;
         seed_z_ff  <= SEED_Z_RESET;
         variant_ff <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            REG_SEED_W:  seed_w_ff  <= csr_pwdata;
            REG_SEED_Z:  seed_z_ff  <= csr_pwdata;
            REG_VARIANT: variant_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- shared step unit ----------------
   // even steps update z, odd steps update w
   assign unit_sel = step_ff[0] ? SEL_W : SEL_Z;
   assign unit_in  = step_ff[0] ? gen_w_ff : gen_z_ff;
   assign word_idx = step_ff[2:1];

   mwcu_step_unit u_step (
      .sel      (unit_sel),
      .word_in  (unit_in),
      .word_out (unit_out)
   );

   always_comb begin
      word_in = {gen_z_ff[HALF_W-1:0], {HALF_W{1'b0}}} + unit_out;
      if (variant_ff && word_idx == 2'd1) begin
         word_in = (word_in & V4_W1_MASK) | V4_W1_SET;
      end else if (variant_ff && word_idx == 2'd2) begin
         word_in = (word_in & V4_W2_MASK) | V4_W2_SET;
      end
   end

   // ---------------- character emit ----------------
   // nibbles leave low first, so the packed words simply shift right by 4
   assign dash_now = !dash_done_ff &&
                     (nib_ff == 5'd8 || nib_ff == 5'd12 || nib_ff == 5'd16 ||
                      nib_ff == 5'd20);
   assign char_in      = dash_now ? CHAR_DASH : hex_char(data_ff[3:0]);
   assign emit_advance = !rsp_valid_ff || rsp_ready;

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_code  = char_code_ff;
   assign rsp_char_index = char_index_ff;
   assign rsp_last_char  = last_char_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_w_ff     <= SEED_W_RESET;
         gen_z_ff     <= SEED_Z_RESET;
         step_ff      <= '0;
         nib_ff       <= '0;
         dash_done_ff <= 1'b0;
         char_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_EMIT && emit_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  if (req_reseed) begin
                     gen_w_ff <= (seed_w_ff == '0) ? SEED_W_RESET : seed_w_ff;
                     gen_z_ff <= (seed_z_ff == '0) ? SEED_Z_RESET : seed_z_ff;
                  end
                  step_ff  <= '0;
                  state_ff <= ST_DRAW;
               end
            end
            ST_DRAW: begin
               if (!step_ff[0]) begin
                  gen_z_ff <= unit_out;
               end else begin
                  gen_w_ff <= unit_out;
                  data_ff  <= {word_in, data_ff[DATA_W-1:WORD_W]};
               end
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd7) begin
                  nib_ff       <= '0;
                  dash_done_ff <= 1'b0;
                  char_cnt_ff  <= '0;
                  state_ff     <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (emit_advance) begin
                  char_code_ff  <= char_in;
                  char_index_ff <= char_cnt_ff;
                  last_char_ff  <= (char_cnt_ff == INDEX_W'(NUM_CHARS - 1));
                  char_cnt_ff   <= char_cnt_ff + 1'b1;
                  if (dash_now) begin
                     dash_done_ff <= 1'b1;
                  end else begin
                     dash_done_ff <= 1'b0;
                     nib_ff       <= nib_ff + 1'b1;
                     data_ff      <= {4'b0000, data_ff[DATA_W-1:4]};
                  end
                  if (char_cnt_ff == INDEX_W'(NUM_CHARS - 1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: hdl/mwcu_step_unit.sv
// ----------------------------------------------------------------------------
// mwcu_step_unit
// Shared multiply-with-carry step: mult * low half + high half, with the
// multiplier chosen for the z or the w generator word.
// ----------------------------------------------------------------------------
module mwcu_step_unit (
   input  mwcu_pkg::gen_sel_type     sel,
   input  logic [mwcu_pkg::WORD_W-1:0] word_in,
   output logic [mwcu_pkg::WORD_W-1:0] word_out
);
   import mwcu_pkg::*;

   logic [HALF_W-1:0] mult;
   logic [WORD_W-1:0] product;

   always_comb begin
      case (sel)
         SEL_Z:   mult = MULT_Z;
         SEL_W:   mult = MULT_W;
         default: mult = MULT_Z;
      endcase
   end

   assign product  = {{HALF_W{1'b0}}, mult} * {{HALF_W{1'b0}}, word_in[HALF_W-1:0]};
   assign word_out = product + {{HALF_W{1'b0}}, word_in[WORD_W-1:HALF_W]};

endmodule

FILE: bench/uuid_string_checker.sv
// ----------------------------------------------------------------------------
// uuid_string_checker
// Watches the request, character and register ports of the identifier string
// generator. It keeps its own copy of the seed registers and of the two
// multiply-with-carry words, predicts the 36 characters of every accepted
// request and compares each accepted character with the oldest prediction.
// ----------------------------------------------------------------------------
module uuid_string_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_reseed,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [mwcu_pkg::CHAR_W-1:0]   rsp_char_code,
   input  logic [mwcu_pkg::INDEX_W-1:0]  rsp_char_index,
   input  logic                          rsp_last_char,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mwcu_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [mwcu_pkg::WORD_W-1:0]   csr_pwdata,
   input  logic                          csr_pready,
   output int                            mismatch_count,
   output int                            chars_pending
);

   import mwcu_pkg::*;

   localparam logic [15:0] MWC_MUL_Z = 16'd36969;
   localparam logic [15:0] MWC_MUL_W = 16'd18000;

   // version nibble in word 1, variant bits in word 2
   localparam logic [31:0] VERSION_KEEP = 32'hFFF0FFFF;
   localparam logic [31:0] VERSION_BITS = 32'h00040000;
   localparam logic [31:0] VARIANT_KEEP = 32'hFFFFFFF3;
   localparam logic [31:0] VARIANT_BITS = 32'h00000008;

   localparam logic [CHAR_W-1:0] ASCII_DASH = 7'h2D;
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] ASCII_A    = 7'h61;

   typedef struct packed {
      logic [CHAR_W-1:0]  code;
      logic [INDEX_W-1:0] pos;
      logic               last;
   } char_item_type;

   logic [31:0]   seed_w_reg;
   logic [31:0]   seed_z_reg;
   logic          v4_mode;
   logic [31:0]   mwc_w;
   logic [31:0]   mwc_z;
   char_item_type expected_chars[$];

   function automatic logic [31:0] mwc_step(input logic [31:0] x, input logic [15:0] mul);
      return {16'h0000, mul} * {16'h0000, x[15:0]} + {16'h0000, x[31:16]};
   endfunction

   function automatic logic [CHAR_W-1:0] nibble_ascii(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return ASCII_ZERO + {3'b000, nib};
      end
      return ASCII_A + {3'b000, nib} - 7'd10;
   endfunction

   task automatic queue_char(input logic [CHAR_W-1:0] code, inout int pos);
      char_item_type item;
      item.code = code;
      item.pos  = pos[INDEX_W-1:0];
      item.last = (pos == NUM_CHARS - 1);
      expected_chars.push_back(item);
      pos++;
   endtask

   task automatic predict_string(input logic reseed);
      logic [31:0] words[4];
      logic [7:0]  byte_val;
      int          pos;
      pos = 0;
      if (reseed) begin
         mwc_w = (seed_w_reg != 32'd0) ? seed_w_reg : 32'd1;
         mwc_z = (seed_z_reg != 32'd0) ? seed_z_reg : 32'd2;
      end
      for (int k = 0; k < 4; k++) begin
         mwc_z = mwc_step(mwc_z, MWC_MUL_Z);
         mwc_w = mwc_step(mwc_w, MWC_MUL_W);
         words[k] = (mwc_z << 16) + mwc_w;
      end
      if (v4_mode) begin
         words[1] = (words[1] & VERSION_KEEP) | VERSION_BITS;
         words[2] = (words[2] & VARIANT_KEEP) | VARIANT_BITS;
      end
      // bytes go out least significant first, low nibble first
      for (int b = 0; b < 16; b++) begin
         byte_val = words[b / 4][8 * (b % 4) +: 8];
         if ((b % 2 == 0) && (b >= 4) && (b <= 10)) begin
            queue_char(ASCII_DASH, pos);
         end
         queue_char(nibble_ascii(byte_val[3:0]), pos);
         queue_char(nibble_ascii(byte_val[7:4]), pos);
      end
   endtask

   always @(posedge clock) begin : monitor
      char_item_type got;
      char_item_type want;
      if (reset) begin
         seed_w_reg = 32'd1;
         seed_z_reg = 32'd2;
         v4_mode    = 1'b1;
         mwc_w      = 32'd1;
         mwc_z      = 32'd2;
         expected_chars.delete();
      end else begin
         // a character at the same edge as a new request belongs to an older one
         if (rsp_valid && rsp_ready) begin
            got.code = rsp_char_code;
            got.pos  = rsp_char_index;
            got.last = rsp_last_char;
            if (expected_chars.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: unexpected char code=%h index=%0d last=%b",
                           got.code, got.pos, got.last);
               end
            end else begin
               want = expected_chars.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display({"mismatch: code exp %h got %h, index exp %0d got %0d,",
                               " last exp %b got %b"},
                              want.code, got.code, want.pos, got.pos, want.last, got.last);
                  end
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[ADDR_W-1:2])
               REG_SEED_W:  seed_w_reg = csr_pwdata;
               REG_SEED_Z:  seed_z_reg = csr_pwdata;
               REG_VARIANT: v4_mode    = csr_pwdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_string(req_reseed);
         end
      end
      chars_pending = expected_chars.size();
   end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives requests and seed/mode register writes into the identifier string
// generator, with random gaps on both channels, a long output stall and
// drained pauses. The checker predicts and compares every character.
// ----------------------------------------------------------------------------
module testbench;

   import mwcu_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_reseed;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [CHAR_W-1:0]    rsp_char_code;
   logic [INDEX_W-1:0]   rsp_char_index;
   logic                 rsp_last_char;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [ADDR_W-1:0]    csr_paddr;
   logic [WORD_W-1:0]    csr_pwdata;
   logic [WORD_W-1:0]    csr_prdata;
   logic                 csr_pready;
   int                   mismatch_count;
   int                   chars_pending;

   bit                   sender_idle;
   bit                   receiver_idle;
   int                   hold_cycles;

   mwc_uuid_string_generator uut (.*);

   uuid_string_checker string_check (.*);

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic write_csr(input logic [1:0] idx, input logic [WORD_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic offer_request(input logic reseed);
      int gap;
      @(negedge clock);
      gap = sender_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_reseed <= reseed;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering and wait for every predicted character
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (chars_pending != 0) @(negedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_seed();
      case ($urandom_range(0, 5))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // output side: per character gap, occasional long hold-off
   initial begin : receiver
      int gap;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         gap = receiver_idle ? $urandom_range(0, 9) : 0;
         if (hold_cycles > 0) begin
            gap = hold_cycles;
            hold_cycles = 0;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_reseed    = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      hold_cycles   = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // generator state straight from reset, then reload from reset seeds
      offer_request(1'b0);
      offer_request(1'b1);
      offer_request(1'b0);
      drain();

      // zero seeds fall back to 1 and 2, plain random words
      write_csr(REG_SEED_W, 32'h0000_0000);
      write_csr(REG_SEED_Z, 32'h0000_0000);
      write_csr(REG_VARIANT, 32'h0000_0000);
      offer_request(1'b1);
      offer_request(1'b0);
      drain();

      // all-ones seeds wrap hard; upper mode bits are don't care
      write_csr(REG_SEED_W, 32'hFFFF_FFFF);
      write_csr(REG_SEED_Z, 32'hFFFF_FFFF);
      write_csr(REG_VARIANT, 32'hFFFF_FFFF);
      offer_request(1'b1);
      offer_request(1'b0);
      offer_request(1'b1);
      drain();

      // write to an unmapped register must change nothing
      write_csr(REG_UNUSED, $urandom());
      write_csr(REG_SEED_W, 32'h8000_0000);
      write_csr(REG_SEED_Z, 32'h0000_FFFF);
      write_csr(REG_VARIANT, 32'hFFFF_FFFE);
      offer_request(1'b1);
      offer_request(1'b0);
      drain();

      for (int phase = 0; phase < 15; phase++) begin
         if ($urandom_range(0, 1)) write_csr(REG_SEED_W, pick_seed());
         if ($urandom_range(0, 1)) write_csr(REG_SEED_Z, pick_seed());
         if ($urandom_range(0, 1)) write_csr(REG_VARIANT, $urandom());
         if ($urandom_range(0, 5) == 0) write_csr(REG_UNUSED, $urandom());
         sender_idle   = (phase % 5 != 0);
         receiver_idle = (phase % 5 != 0) && (phase % 4 != 1);
         if (phase == 3 || phase == 11) begin
            hold_cycles = 300;
         end
         for (int k = 0; k < 14; k++) begin
            if (k == 7 && $urandom_range(0, 2) == 0) begin
               drain();
            end
            offer_request($urandom_range(0, 3) == 0);
         end
         drain();
      end

      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && chars_pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
